/* rtl/core/rmp_pkg.sv */
package rmp_pkg;

  localparam int MAX_DEPTH  = 8;
  localparam int COUNT_BITS = 32;
  localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W      = $clog2(MAX_DEPTH);
  localparam int Q_DEPTH    = 4;
  localparam int QP_W       = $clog2(Q_DEPTH);
  localparam int QC_W       = $clog2(Q_DEPTH + 1);
  localparam int TOK_W      = 32;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_BEGIN   = 2'd1;
  localparam logic [1:0] EV_END     = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  localparam logic [2:0] K_SIMPLE = 3'd0;
  localparam logic [2:0] K_ERRSTR = 3'd1;
  localparam logic [2:0] K_INT    = 3'd2;
  localparam logic [2:0] K_BULK   = 3'd3;
  localparam logic [2:0] K_NULL   = 3'd4;
  localparam logic [2:0] K_ARRAY  = 3'd5;
  localparam logic [2:0] K_INLINE = 3'd6;
  localparam logic [2:0] K_TOKEN  = 3'd7;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_PREFIX   = 3'd1;
  localparam logic [2:0] E_NUMBER   = 3'd2;
  localparam logic [2:0] E_CRLF     = 3'd3;
  localparam logic [2:0] E_NEGCOUNT = 3'd4;
  localparam logic [2:0] E_DEEP     = 3'd5;
  localparam logic [2:0] E_EMPTY    = 3'd6;
  localparam logic [2:0] E_LONG     = 3'd7;

  typedef struct packed {
    logic [1:0]  ev;
    logic [2:0]  kind;
    logic [7:0]  pay;
    logic [63:0] num;
    logic [3:0]  depth;
    logic [3:0]  closed;
    logic        done;
    logic [2:0]  err;
    logic        last;
  } evt_t;

  typedef struct packed {
    evt_t       e0;
    evt_t       e1;
    logic [1:0] cnt;
  } push_t;

  function automatic evt_t mk_ev(logic [1:0] ev, logic [2:0] kind, logic [7:0] pay,
                                 logic [63:0] num, logic [3:0] depth,
                                 logic [3:0] closed, logic done, logic [2:0] err);
    evt_t r;
    r.ev = ev; r.kind = kind; r.pay = pay; r.num = num; r.depth = depth;
    r.closed = closed; r.done = done; r.err = err; r.last = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/resp_message_parser_unit.sv */
// RESP2 byte-stream parser: one word (byte) in, begin/payload/end/error words out.
// Throughput: one byte per cycle while the result side keeps up; a byte that
//   yields two results leaves them to drain one word at a time, so the 4-entry result queue sets the pace.
// A byte's results are registered into the result queue and reach out_* once older entries have drained.
// Reset (rst_n low, synchronous): parser waits for a message prefix, queue empty;
//   the count stack is left as is and only read below the live level.
module resp_message_parser_unit import rmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_start_over,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_res,
  output logic [2:0]         out_element_kind,
  output logic [7:0]         out_payload_byte,
  output logic signed [63:0] out_number,
  output logic [3:0]         out_nesting_depth,
  output logic [3:0]         out_levels_closed,
  output logic               out_message_done,
  output logic [2:0]         out_error_code,
  output logic               out_last
);

  push_t push;
  evt_t  head;
  logic  room;
  logic  fire;

  // front takes a byte only when the queue can absorb two results
  assign in_ready = room;
  assign fire     = in_valid && in_ready;

  // front: phase machine, number accumulation, array count stack
  rmp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .byte_i     (in_byte_value),
    .start_over (in_start_over),
    .push       (push)
  );

  // back: result queue, drained one word per cycle while out_ready is high
  rmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_event_res     = head.ev;
  assign out_element_kind  = head.kind;
  assign out_payload_byte  = head.pay;
  assign out_number        = $signed(head.num);
  assign out_nesting_depth = head.depth;
  assign out_levels_closed = head.closed;
  assign out_message_done  = head.done;
  assign out_error_code    = head.err;
  assign out_last          = head.last;

endmodule

/* rtl/core/rmp_front.sv */
module rmp_front import rmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_i,
  input  logic       start_over,
  output push_t      push
);

  typedef enum logic [9:0] {
    PH_PREFIX    = 10'b0000000001,
    PH_LINE      = 10'b0000000010,
    PH_NUM_FIRST = 10'b0000000100,
    PH_NUM_DIGIT = 10'b0000001000,
    PH_NUM_MORE  = 10'b0000010000,
    PH_NUM_LF    = 10'b0000100000,
    PH_BULK_DATA = 10'b0001000000,
    PH_BULK_CR   = 10'b0010000000,
    PH_BULK_LF   = 10'b0100000000,
    PH_INLINE    = 10'b1000000000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [2:0]              kind_r, kind_nxt;
  logic                    neg_r, neg_nxt;
  logic [62:0]             acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]   bulk_r, bulk_nxt;
  logic                    crp_r, crp_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic                    tok_open_r, tok_open_nxt;
  logic [TOK_W-1:0]        tok_cnt_r, tok_cnt_nxt;
  logic                    err_r, err_nxt;
  logic [COUNT_BITS-1:0]   stack_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0]    one_r;

  // pop cascade for an element end
  logic [LVL_W-1:0]        pop_cnt, pop_level;
  logic [IDX_W-1:0]        top_idx;
  logic [COUNT_BITS-1:0]   top_val;
  logic                    run;

  logic                    is_dig, is_ws, ovf, over_lim, negv;
  logic [66:0]             prod;
  logic [63:0]             sv;
  logic                    do_inl, fin_req, fail_req, push_we, pop_we, ended;
  logic [2:0]              fin_kind, fail_code;
  logic [63:0]             fin_num;
  evt_t                    e [2];
  logic [1:0]              n;

  always_comb begin
    run = 1'b1;
    pop_cnt = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (run && (k < int'(level_r)) && one_r[IDX_W'(int'(level_r) - 1 - k)]) begin
        pop_cnt = pop_cnt + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    pop_level = level_r - pop_cnt;
    top_idx   = IDX_W'(pop_level - 1'b1);
    top_val   = stack_r[top_idx];
  end

  assign is_dig   = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign is_ws    = (byte_i == CH_SP) || (byte_i == CH_TAB) || (byte_i == CH_LF) ||
                    (byte_i == CH_VT) || (byte_i == CH_FF) || (byte_i == CH_CR);
  // acc*10 + digit, overflow past the signed 64-bit maximum
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 67'(byte_i - CH_0);
  assign ovf      = |prod[66:63];
  assign over_lim = |acc_r[62:COUNT_BITS];
  assign negv     = neg_r && (acc_r != '0);
  assign sv       = negv ? (64'd0 - {1'b0, acc_r}) : {1'b0, acc_r};

  always_comb begin
    phase_nxt = phase_r; kind_nxt = kind_r; neg_nxt = neg_r; acc_nxt = acc_r;
    bulk_nxt = bulk_r; crp_nxt = crp_r; level_nxt = level_r;
    tok_open_nxt = tok_open_r; tok_cnt_nxt = tok_cnt_r; err_nxt = err_r;
    do_inl = 1'b0; fin_req = 1'b0; fail_req = 1'b0; push_we = 1'b0; pop_we = 1'b0;
    ended = 1'b0;
    fin_kind = K_SIMPLE; fin_num = '0; fail_code = E_NONE;
    e[0] = '0; e[1] = '0; n = '0;

    if (start_over) begin
      phase_nxt = PH_PREFIX; kind_nxt = K_SIMPLE; neg_nxt = 1'b0; acc_nxt = '0;
      bulk_nxt = '0; crp_nxt = 1'b0; level_nxt = '0; tok_open_nxt = 1'b0;
      tok_cnt_nxt = '0; err_nxt = 1'b0;
    end else if (!err_r) begin
      case (phase_r)
        PH_PREFIX: begin
          crp_nxt = 1'b0;
          if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
            kind_nxt = (byte_i == CH_PLUS) ? K_SIMPLE : K_ERRSTR;
            e[n[0]] = mk_ev(EV_BEGIN, kind_nxt, 8'd0, 64'd0, 4'(level_r), 4'd0, 1'b0, E_NONE);
            n = n + 1'b1;
            phase_nxt = PH_LINE;
          end else if (byte_i == CH_COLON || byte_i == CH_DOLL || byte_i == CH_STAR) begin
            kind_nxt = (byte_i == CH_COLON) ? K_INT : (byte_i == CH_DOLL) ? K_BULK : K_ARRAY;
            neg_nxt = 1'b0;
            acc_nxt = '0;
            phase_nxt = PH_NUM_FIRST;
          end else if (level_r == '0) begin
            kind_nxt = K_INLINE;
            tok_cnt_nxt = '0;
            tok_open_nxt = 1'b0;
            e[n[0]] = mk_ev(EV_BEGIN, K_INLINE, 8'd0, 64'd0, 4'd0, 4'd0, 1'b0, E_NONE);
            n = n + 1'b1;
            phase_nxt = PH_INLINE;
            do_inl = 1'b1;
          end else begin
            fail_req = 1'b1; fail_code = E_PREFIX;
          end
        end
        PH_LINE: begin
          if (crp_r && byte_i == CH_LF) begin
            fin_req = 1'b1; fin_kind = kind_r; fin_num = '0;
          end else begin
            if (crp_r) begin
              e[n[0]] = mk_ev(EV_PAYLOAD, kind_r, CH_CR, 64'd0, 4'(level_r), 4'd0, 1'b0,
                              E_NONE);
              n = n + 1'b1;
              crp_nxt = 1'b0;
            end
            if (byte_i == CH_CR) begin
              crp_nxt = 1'b1;
            end else begin
              e[n[0]] = mk_ev(EV_PAYLOAD, kind_r, byte_i, 64'd0, 4'(level_r), 4'd0, 1'b0,
                              E_NONE);
              n = n + 1'b1;
            end
          end
        end
        PH_NUM_FIRST, PH_NUM_DIGIT, PH_NUM_MORE: begin
          if (is_dig) begin
            if (ovf) begin
              fail_req = 1'b1; fail_code = E_NUMBER;
            end else begin
              acc_nxt = prod[62:0];
              phase_nxt = PH_NUM_MORE;
            end
          end else if (phase_r == PH_NUM_FIRST && byte_i == CH_MINUS) begin
            neg_nxt = 1'b1; phase_nxt = PH_NUM_DIGIT;
          end else if (phase_r == PH_NUM_FIRST && byte_i == CH_PLUS) begin
            phase_nxt = PH_NUM_DIGIT;
          end else if (phase_r == PH_NUM_MORE && byte_i == CH_CR) begin
            phase_nxt = PH_NUM_LF;
          end else begin
            fail_req = 1'b1;
            fail_code = (phase_r == PH_NUM_MORE) ? E_CRLF : E_NUMBER;
          end
        end
        PH_NUM_LF: begin
          if (byte_i != CH_LF) begin
            fail_req = 1'b1; fail_code = E_CRLF;
          end else if (kind_r == K_INT) begin
            e[n[0]] = mk_ev(EV_BEGIN, K_INT, 8'd0, sv, 4'(level_r), 4'd0, 1'b0, E_NONE);
            n = n + 1'b1;
            fin_req = 1'b1; fin_kind = K_INT; fin_num = sv;
          end else if (kind_r == K_BULK) begin
            if (negv) begin
              kind_nxt = K_NULL;
              e[n[0]] = mk_ev(EV_BEGIN, K_NULL, 8'd0, sv, 4'(level_r), 4'd0, 1'b0, E_NONE);
              n = n + 1'b1;
              fin_req = 1'b1; fin_kind = K_NULL; fin_num = sv;
            end else if (over_lim) begin
              fail_req = 1'b1; fail_code = E_LONG;
            end else begin
              e[n[0]] = mk_ev(EV_BEGIN, K_BULK, 8'd0, sv, 4'(level_r), 4'd0, 1'b0, E_NONE);
              n = n + 1'b1;
              bulk_nxt = acc_r[COUNT_BITS-1:0];
              phase_nxt = (acc_r != '0) ? PH_BULK_DATA : PH_BULK_CR;
            end
          end else begin
            if (negv) begin
              fail_req = 1'b1; fail_code = E_NEGCOUNT;
            end else if (over_lim) begin
              fail_req = 1'b1; fail_code = E_LONG;
            end else if (acc_r == '0) begin
              e[n[0]] = mk_ev(EV_BEGIN, K_ARRAY, 8'd0, 64'd0, 4'(level_r), 4'd0, 1'b0, E_NONE);
              n = n + 1'b1;
              fin_req = 1'b1; fin_kind = K_ARRAY; fin_num = '0;
            end else if (int'(level_r) >= MAX_DEPTH) begin
              fail_req = 1'b1; fail_code = E_DEEP;
            end else begin
              e[n[0]] = mk_ev(EV_BEGIN, K_ARRAY, 8'd0, sv, 4'(level_r), 4'd0, 1'b0, E_NONE);
              n = n + 1'b1;
              push_we = 1'b1;
              level_nxt = level_r + 1'b1;
              phase_nxt = PH_PREFIX;
            end
          end
        end
        PH_BULK_DATA: begin
          e[n[0]] = mk_ev(EV_PAYLOAD, K_BULK, byte_i, 64'd0, 4'(level_r), 4'd0, 1'b0, E_NONE);
          n = n + 1'b1;
          bulk_nxt = bulk_r - 1'b1;
          if (bulk_r == COUNT_BITS'(1)) phase_nxt = PH_BULK_CR;
        end
        PH_BULK_CR: begin
          if (byte_i == CH_CR) phase_nxt = PH_BULK_LF;
          else begin
            fail_req = 1'b1; fail_code = E_CRLF;
          end
        end
        PH_BULK_LF: begin
          if (byte_i == CH_LF) begin
            fin_req = 1'b1; fin_kind = K_BULK; fin_num = {1'b0, acc_r};
          end else begin
            fail_req = 1'b1; fail_code = E_CRLF;
          end
        end
        PH_INLINE: do_inl = 1'b1;
        default: phase_nxt = PH_PREFIX;
      endcase

      // inline command byte
      if (do_inl) begin
        if (crp_nxt) begin
          crp_nxt = 1'b0;
          if (byte_i == CH_LF) begin
            ended = 1'b1;
            if (tok_cnt_nxt == '0) begin
              fail_req = 1'b1; fail_code = E_EMPTY;
            end else begin
              e[n[0]] = mk_ev(EV_END, K_INLINE, 8'd0, 64'(tok_cnt_nxt), 4'd0, 4'd1, 1'b1,
                              E_NONE);
              n = n + 1'b1;
              phase_nxt = PH_PREFIX;
            end
          end
        end
        if (!ended) begin
          if (is_ws) begin
            if (tok_open_nxt) begin
              e[n[0]] = mk_ev(EV_END, K_TOKEN, 8'd0, 64'(tok_cnt_nxt), 4'd1, 4'd1, 1'b0,
                              E_NONE);
              n = n + 1'b1;
              tok_open_nxt = 1'b0;
            end
            if (byte_i == CH_CR) crp_nxt = 1'b1;
          end else if (!tok_open_nxt) begin
            tok_open_nxt = 1'b1;
            if (tok_cnt_nxt != '1) tok_cnt_nxt = tok_cnt_nxt + 1'b1;
            e[n[0]] = mk_ev(EV_BEGIN, K_TOKEN, byte_i, 64'(tok_cnt_nxt), 4'd1, 4'd0, 1'b0,
                            E_NONE);
            n = n + 1'b1;
          end else begin
            e[n[0]] = mk_ev(EV_PAYLOAD, K_TOKEN, byte_i, 64'd0, 4'd1, 4'd0, 1'b0, E_NONE);
            n = n + 1'b1;
          end
        end
      end

      if (fin_req) begin
        e[n[0]] = mk_ev(EV_END, fin_kind, 8'd0, fin_num, 4'(level_r), 4'(pop_cnt + 1'b1),
                        (pop_level == '0), E_NONE);
        n = n + 1'b1;
        level_nxt = pop_level;
        pop_we = (pop_level != '0);
        phase_nxt = PH_PREFIX;
        crp_nxt = 1'b0;
      end

      if (fail_req) begin
        e[n[0]] = mk_ev(EV_ERROR, kind_nxt, 8'd0, 64'd0, 4'(level_r), 4'd0, 1'b0, fail_code);
        n = n + 1'b1;
        err_nxt = 1'b1;
      end

      if (n == 2'd1) e[0].last = 1'b1;
      if (n == 2'd2) e[1].last = 1'b1;
    end
  end

  always_comb begin
    push.e0  = e[0];
    push.e1  = e[1];
    push.cnt = fire ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX; kind_r <= K_SIMPLE; neg_r <= 1'b0; acc_r <= '0;
      bulk_r <= '0; crp_r <= 1'b0; level_r <= '0; tok_open_r <= 1'b0;
      tok_cnt_r <= '0; err_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt; kind_r <= kind_nxt; neg_r <= neg_nxt; acc_r <= acc_nxt;
      bulk_r <= bulk_nxt; crp_r <= crp_nxt; level_r <= level_nxt;
      tok_open_r <= tok_open_nxt; tok_cnt_r <= tok_cnt_nxt; err_r <= err_nxt;
    end
  end

  // count stack: push a new array, or decrement the surviving top on an end
  always_ff @(posedge clk) begin
    if (fire && !start_over && push_we) begin
      stack_r[IDX_W'(level_r)] <= acc_r[COUNT_BITS-1:0];
      one_r[IDX_W'(level_r)]   <= (acc_r == 63'd1);
    end else if (fire && !start_over && pop_we) begin
      stack_r[top_idx] <= top_val - 1'b1;
      one_r[top_idx]   <= (top_val == COUNT_BITS'(2));
    end
  end

endmodule

/* rtl/core/rmp_queue.sv */
module rmp_queue import rmp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output evt_t  head
);

  evt_t             mem_r [Q_DEPTH];
  logic [QP_W-1:0]  wr_r, rd_r;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;
  logic             pop;

  assign room      = (int'(cnt_r) <= Q_DEPTH - 2);
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + QC_W'(push.cnt) - QC_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QP_W'(push.cnt);
      rd_r  <= rd_r + QP_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.e0;
    if (push.cnt == 2'd2) mem_r[wr_r + 1'b1] <= push.e1;
  end

endmodule

/* rtl/core/rmp_checker.sv */
module rmp_checker import rmp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic [3:0] out_levels_closed,
  input logic       out_message_done,
  input logic [2:0] out_error_code,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) && $stable(out_last))
    else $error("result word changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ERROR |->
      out_error_code != E_NONE && !out_message_done && out_levels_closed == 4'd0 && out_last)
    else $error("malformed error word");

  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_END |-> out_levels_closed != 4'd0)
    else $error("end word closes nothing");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind resp_message_parser_unit rmp_checker u_rmp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_event_res     (out_event_res),
  .out_levels_closed (out_levels_closed),
  .out_message_done  (out_message_done),
  .out_error_code    (out_error_code),
  .out_last          (out_last)
);
